@@ hw/rtl/iev_pkg.sv @@
`timescale 1ns / 1ps

package iev_pkg;

  // default character store depth
  localparam int DEF_FIFO_DEPTH = 64;

  // result queue between the decoder and the output port
  localparam int QUEUE_DEPTH = 3;

  // command codes
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // event types
  localparam logic [15:0] EV_SYNC = 16'h0000;
  localparam logic [15:0] EV_KEY  = 16'h0001;
  localparam logic [15:0] EV_ABS  = 16'h0003;

  // absolute axes
  localparam logic [15:0] AXIS_X = 16'h0000;
  localparam logic [15:0] AXIS_Y = 16'h0001;

  // mouse button key codes
  localparam logic [15:0] BTN_LEFT   = 16'h0110;
  localparam logic [15:0] BTN_RIGHT  = 16'h0111;
  localparam logic [15:0] BTN_MIDDLE = 16'h0112;

  // key state that queues a character
  localparam logic [31:0] KEY_PRESS = 32'd1;

  // one result beat
  typedef struct packed {
    logic signed [31:0] pointer_x;
    logic signed [31:0] pointer_y;
    logic [2:0]         button_bits;
    logic               frame_changed;
    logic               char_valid;
    logic [6:0]         char_out;
    logic [6:0]         chars_waiting;
    logic               char_dropped;
  } result_t;

  // us layout key code to ascii, zero for unmapped codes
  function automatic logic [6:0] keymap_lookup(input logic [15:0] code);
    logic [6:0] ch;
    case (code)
      16'd1:   ch = 7'h1b;
      16'd2:   ch = 7'h31;
      16'd3:   ch = 7'h32;
      16'd4:   ch = 7'h33;
      16'd5:   ch = 7'h34;
      16'd6:   ch = 7'h35;
      16'd7:   ch = 7'h36;
      16'd8:   ch = 7'h37;
      16'd9:   ch = 7'h38;
      16'd10:  ch = 7'h39;
      16'd11:  ch = 7'h30;
      16'd12:  ch = 7'h2d;
      16'd13:  ch = 7'h3d;
      16'd14:  ch = 7'h08;
      16'd15:  ch = 7'h09;
      16'd16:  ch = 7'h71;
      16'd17:  ch = 7'h77;
      16'd18:  ch = 7'h65;
      16'd19:  ch = 7'h72;
      16'd20:  ch = 7'h74;
      16'd21:  ch = 7'h79;
      16'd22:  ch = 7'h75;
      16'd23:  ch = 7'h69;
      16'd24:  ch = 7'h6f;
      16'd25:  ch = 7'h70;
      16'd26:  ch = 7'h5b;
      16'd27:  ch = 7'h5d;
      16'd28:  ch = 7'h0a;
      16'd30:  ch = 7'h61;
      16'd31:  ch = 7'h73;
      16'd32:  ch = 7'h64;
      16'd33:  ch = 7'h66;
      16'd34:  ch = 7'h67;
      16'd35:  ch = 7'h68;
      16'd36:  ch = 7'h6a;
      16'd37:  ch = 7'h6b;
      16'd38:  ch = 7'h6c;
      16'd39:  ch = 7'h3b;
      16'd40:  ch = 7'h27;
      16'd41:  ch = 7'h60;
      16'd43:  ch = 7'h5c;
      16'd44:  ch = 7'h7a;
      16'd45:  ch = 7'h78;
      16'd46:  ch = 7'h63;
      16'd47:  ch = 7'h76;
      16'd48:  ch = 7'h62;
      16'd49:  ch = 7'h6e;
      16'd50:  ch = 7'h6d;
      16'd51:  ch = 7'h2c;
      16'd52:  ch = 7'h2e;
      16'd53:  ch = 7'h2f;
      16'd57:  ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ hw/rtl/input_event_decoder.sv @@
`timescale 1ns / 1ps

// Input event decoder: takes pointer/keyboard events or key-read requests and
// returns one result beat per item. One item is taken every cycle while
// in_stall is low. An accepted item is first registered as the decoded beat,
// together with the registered read port of the character store; the beat
// then enters the result queue, from which it can be taken. This three-entry
// queue sits before the output, so input keeps flowing while a result waits
// to be taken. Input stalls only when that queue and the item in flight fill
// it. Absolute X/Y and button events update pending state, a sync
// commits it, and key presses are mapped through a US layout into a
// FIFO_DEPTH-entry character store.
module input_event_decoder import iev_pkg::*; #(
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [15:0]        event_type,
  input  logic [15:0]        event_code,
  input  logic signed [31:0] event_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pointer_x,
  output logic signed [31:0] pointer_y,
  output logic [2:0]         button_bits,
  output logic               frame_changed,
  output logic               char_valid,
  output logic [6:0]         char_out,
  output logic [6:0]         chars_waiting,
  output logic               char_dropped
);

  logic       accept;
  logic       res_valid;
  result_t    res;
  result_t    head_res;
  logic [1:0] q_count;

  // room for the queued results plus the one in flight
  assign in_stall = ({1'b0, q_count} + {2'b00, res_valid}) > 3'(QUEUE_DEPTH - 1);
  assign accept   = in_valid && !in_stall;

  iev_core #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .event_type  (event_type),
    .event_code  (event_code),
    .event_value (event_value),
    .res_valid   (res_valid),
    .res         (res)
  );

  iev_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_res   (res),
    .pop        (out_valid && !out_stall),
    .head_valid (out_valid),
    .head_res   (head_res),
    .count      (q_count)
  );

  // output beat fields
  assign pointer_x     = head_res.pointer_x;
  assign pointer_y     = head_res.pointer_y;
  assign button_bits   = head_res.button_bits;
  assign frame_changed = head_res.frame_changed;
  assign char_valid    = head_res.char_valid;
  assign char_out      = head_res.char_out;
  assign chars_waiting = head_res.chars_waiting;
  assign char_dropped  = head_res.char_dropped;

endmodule

@@ hw/rtl/iev_core.sv @@
`timescale 1ns / 1ps

module iev_core import iev_pkg::*; #(
  parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               command,
  input  logic [15:0]        event_type,
  input  logic [15:0]        event_code,
  input  logic signed [31:0] event_value,
  output logic               res_valid,
  output result_t            res
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

  // decoder state
  logic signed [31:0] pending_x, pending_x_next;
  logic signed [31:0] pending_y, pending_y_next;
  logic [2:0]         pending_buttons, pending_buttons_next;
  logic signed [31:0] committed_x, committed_x_next;
  logic signed [31:0] committed_y, committed_y_next;
  logic [2:0]         committed_buttons, committed_buttons_next;
  logic [PW-1:0]      write_pointer, write_pointer_next;
  logic [PW-1:0]      read_pointer, read_pointer_next;
  logic [CW-1:0]      fill_count, fill_count_next;

  // character store
  logic [6:0] char_store [FIFO_DEPTH];
  logic [6:0] rd_data;
  logic       mem_we;
  logic       mem_re;
  logic [6:0] key_char;
  logic [2:0] btn_mask;

  // first stage result, character filled in from rd_data
  result_t s1_res;
  result_t s1_res_next;
  logic    s1_valid;

  // decode one item
  always_comb begin
    pending_x_next         = pending_x;
    pending_y_next         = pending_y;
    pending_buttons_next   = pending_buttons;
    committed_x_next       = committed_x;
    committed_y_next       = committed_y;
    committed_buttons_next = committed_buttons;
    write_pointer_next     = write_pointer;
    read_pointer_next      = read_pointer;
    fill_count_next        = fill_count;
    mem_we                 = 1'b0;
    mem_re                 = 1'b0;
    s1_res_next            = '0;
    key_char               = keymap_lookup(event_code);

    case (event_code)
      BTN_LEFT:   btn_mask = 3'b001;
      BTN_RIGHT:  btn_mask = 3'b010;
      BTN_MIDDLE: btn_mask = 3'b100;
      default:    btn_mask = 3'b000;
    endcase

    if (command == CMD_READ) begin
      if (fill_count != '0) begin
        mem_re                 = 1'b1;
        read_pointer_next      = (read_pointer == LAST_PTR) ? '0 : read_pointer + PW'(1);
        fill_count_next        = fill_count - CW'(1);
        s1_res_next.char_valid = 1'b1;
      end
    end else begin
      case (event_type)
        EV_ABS: begin
          if (event_code == AXIS_X) begin
            pending_x_next = event_value;
          end else if (event_code == AXIS_Y) begin
            pending_y_next = event_value;
          end
        end
        EV_KEY: begin
          if (btn_mask != 3'b000) begin
            if (event_value != '0) begin
              pending_buttons_next = pending_buttons | btn_mask;
            end else begin
              pending_buttons_next = pending_buttons & ~btn_mask;
            end
          end else if (event_value == KEY_PRESS && key_char != 7'h00) begin
            if (fill_count >= FULL_CNT) begin
              s1_res_next.char_dropped = 1'b1;
            end else begin
              mem_we             = 1'b1;
              write_pointer_next = (write_pointer == LAST_PTR) ? '0
                                                               : write_pointer + PW'(1);
              fill_count_next    = fill_count + CW'(1);
            end
          end
        end
        EV_SYNC: begin
          if (pending_x != committed_x || pending_y != committed_y ||
              pending_buttons != committed_buttons) begin
            committed_x_next          = pending_x;
            committed_y_next          = pending_y;
            committed_buttons_next    = pending_buttons;
            s1_res_next.frame_changed = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    s1_res_next.pointer_x     = committed_x_next;
    s1_res_next.pointer_y     = committed_y_next;
    s1_res_next.button_bits   = committed_buttons_next;
    s1_res_next.chars_waiting = 7'(fill_count_next);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_x         <= '0;
      pending_y         <= '0;
      pending_buttons   <= '0;
      committed_x       <= '0;
      committed_y       <= '0;
      committed_buttons <= '0;
      write_pointer     <= '0;
      read_pointer      <= '0;
      fill_count        <= '0;
      s1_valid          <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        pending_x         <= pending_x_next;
        pending_y         <= pending_y_next;
        pending_buttons   <= pending_buttons_next;
        committed_x       <= committed_x_next;
        committed_y       <= committed_y_next;
        committed_buttons <= committed_buttons_next;
        write_pointer     <= write_pointer_next;
        read_pointer      <= read_pointer_next;
        fill_count        <= fill_count_next;
      end
    end
  end

  // first stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= s1_res_next;
    end
  end

  // character store, registered read port
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      char_store[write_pointer] <= key_char;
    end
    if (accept && mem_re) begin
      rd_data <= char_store[read_pointer];
    end
  end

  // merge read data into the result
  always_comb begin
    res          = s1_res;
    res.char_out = s1_res.char_valid ? rd_data : 7'h00;
  end

  assign res_valid = s1_valid;

endmodule

@@ hw/rtl/iev_out_queue.sv @@
`timescale 1ns / 1ps

module iev_out_queue import iev_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  input  logic    pop,
  output logic    head_valid,
  output result_t head_res,
  output logic [1:0] count
);

  localparam logic [1:0] LAST_SLOT = 2'(QUEUE_DEPTH - 1);

  result_t    entries [QUEUE_DEPTH];
  logic [1:0] head;
  logic [1:0] tail;

  // queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == LAST_SLOT) ? '0 : tail + 2'd1;
      end
      if (pop) begin
        head <= (head == LAST_SLOT) ? '0 : head + 2'd1;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_res;
    end
  end

  assign head_valid = (count != '0);
  assign head_res   = entries[head];

endmodule
